>>> src/tmlf_pkg.sv
// tmlf_pkg: shared types, constants and the microcode program of the trimmed-mean lux filter
// used by tmlf_seq, tmlf_window, tmlf_dpath and trimmed_mean_lux_filter_top
`default_nettype none

package tmlf_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 10;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned LUX_W = 20;

	// working register width, reciprocal shift and product width
	localparam int unsigned X_W = 24;
	localparam int unsigned REC_SHIFT = 24;
	localparam int unsigned REC_W = 25;
	localparam int unsigned P_W = X_W + REC_W;

	localparam int unsigned K_SCALE = 10;
	localparam int unsigned K_GAIN = 139;
	localparam int unsigned DIV_CAL1 = 12;
	localparam int unsigned DIV_CAL2 = 13;
	localparam int unsigned LUX_OFFSET = 1;

	localparam logic [REC_W-1:0] REC_CAL1 = REC_W'((64'd1 << REC_SHIFT) / DIV_CAL1);
	localparam logic [REC_W-1:0] REC_CAL2 = REC_W'((64'd1 << REC_SHIFT) / DIV_CAL2);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LOOP,
		ST_LAST,
		ST_TRIM,
		ST_WREC,
		ST_WMUL,
		ST_WCOR,
		ST_SCALE,
		ST_AREC,
		ST_AMUL,
		ST_ACOR,
		ST_GAIN,
		ST_BREC,
		ST_BMUL,
		ST_BCOR,
		ST_OUT
	} step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACC,
		OP_TRIM,
		OP_MULREC,
		OP_MULDIV,
		OP_CORR,
		OP_SCALE,
		OP_GAIN,
		OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_ALWAYS,
		JMP_MORE
	} jmp_t;

	typedef enum logic [1:0] {
		SEL_WIN,
		SEL_CAL1,
		SEL_CAL2
	} sel_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_FIRST,
		RD_NEXT
	} rd_t;

	typedef struct packed {
		logic  wait_in;
		logic  wait_out;
		jmp_t  jmp;
		step_t target;
		op_t   op;
		sel_t  sel;
		rd_t   rd;
	} ctrl_t;

	localparam ctrl_t CTRL_NOP = '{
		wait_in: 1'b0,
		wait_out: 1'b0,
		jmp: JMP_NONE,
		target: ST_IDLE,
		op: OP_NONE,
		sel: SEL_WIN,
		rd: RD_NONE
	};

	// control store: one word per step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (step)
			ST_IDLE: begin
				c.wait_in = 1'b1;
			end
			ST_CLEAR: begin
				c.op = OP_CLEAR;
				c.rd = RD_FIRST;
			end
			ST_LOOP: begin
				c.op = OP_ACC;
				c.rd = RD_NEXT;
				c.jmp = JMP_MORE;
				c.target = ST_LOOP;
			end
			ST_LAST: c.op = OP_ACC;
			ST_TRIM: c.op = OP_TRIM;
			ST_WREC: begin
				c.op = OP_MULREC;
				c.sel = SEL_WIN;
			end
			ST_WMUL: begin
				c.op = OP_MULDIV;
				c.sel = SEL_WIN;
			end
			ST_WCOR: begin
				c.op = OP_CORR;
				c.sel = SEL_WIN;
			end
			ST_SCALE: c.op = OP_SCALE;
			ST_AREC: begin
				c.op = OP_MULREC;
				c.sel = SEL_CAL1;
			end
			ST_AMUL: begin
				c.op = OP_MULDIV;
				c.sel = SEL_CAL1;
			end
			ST_ACOR: begin
				c.op = OP_CORR;
				c.sel = SEL_CAL1;
			end
			ST_GAIN: c.op = OP_GAIN;
			ST_BREC: begin
				c.op = OP_MULREC;
				c.sel = SEL_CAL2;
			end
			ST_BMUL: begin
				c.op = OP_MULDIV;
				c.sel = SEL_CAL2;
			end
			ST_BCOR: begin
				c.op = OP_CORR;
				c.sel = SEL_CAL2;
			end
			ST_OUT: begin
				c.op = OP_OUT;
				c.wait_out = 1'b1;
				c.jmp = JMP_ALWAYS;
				c.target = ST_IDLE;
			end
			default: begin
				c.jmp = JMP_ALWAYS;
				c.target = ST_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/tmlf_seq.sv
// tmlf_seq: step counter and control store lookup with conditional jumps
// depends on tmlf_pkg
`default_nettype none

module tmlf_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic            out_busy,
	input  wire logic            more,
	output tmlf_pkg::ctrl_t      ctrl,
	output logic                 exec
);
	import tmlf_pkg::*;

	step_t step_q;
	logic  hold;
	logic  taken;

	assign ctrl = ucode(step_q);
	assign hold = (ctrl.wait_in && !in_fire) || (ctrl.wait_out && out_busy);
	assign exec = !hold;

	always_comb begin
		case (ctrl.jmp)
			JMP_ALWAYS: taken = 1'b1;
			JMP_MORE:   taken = more;
			default:    taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (!hold) begin
			if (taken) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_t'(step_q + 5'd1);
			end
		end
	end

endmodule

`default_nettype wire

>>> src/tmlf_window.sv
// tmlf_window: sample window memory, per-entry valid bits with fill value, write position
// and read index; depends on tmlf_pkg
`default_nettype none

module tmlf_window #(
	parameter int unsigned WINDOW_DEPTH = tmlf_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [tmlf_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic                            restart,
	input  tmlf_pkg::ctrl_t                      ctrl,
	input  wire logic                            exec,
	output logic                                 more,
	output logic [tmlf_pkg::SAMPLE_W-1:0]        rd_value
);
	import tmlf_pkg::*;

	localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW_DEPTH - 1);

	logic [SAMPLE_W-1:0]     mem [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] vld_q;
	logic [IDX_W-1:0]        pos_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    filled_q;
	logic                    rd_vld_q;
	logic [SAMPLE_W-1:0]     rd_data_q;
	logic [SAMPLE_W-1:0]     fill_q;
	logic                    fill_now;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;

	assign fill_now = restart || !filled_q;
	assign rd_en    = exec && (ctrl.rd != RD_NONE);
	assign rd_addr  = (ctrl.rd == RD_FIRST) ? '0 : idx_q;
	assign more     = (idx_q != LAST);
	assign rd_value = rd_vld_q ? rd_data_q : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			pos_q    <= '0;
			idx_q    <= '0;
			filled_q <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				filled_q <= 1'b1;
				pos_q    <= (pos_q == LAST) ? '0 : pos_q + IDX_W'(1);
				if (fill_now) begin
					vld_q <= '0;
				end else begin
					vld_q[pos_q] <= 1'b1;
				end
			end
			if (rd_en) begin
				idx_q    <= rd_addr + IDX_W'(1);
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !fill_now) begin
			mem[pos_q] <= sample;
		end
		if (wr_en && fill_now) begin
			fill_q <= sample;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/tmlf_dpath.sv
// tmlf_dpath: sum/max/min accumulators, reciprocal divide with correction, lux scaling
// and the output register; depends on tmlf_pkg
`default_nettype none

module tmlf_dpath #(
	parameter int unsigned WINDOW_DEPTH = tmlf_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  tmlf_pkg::ctrl_t                    ctrl,
	input  wire logic                          exec,
	input  wire logic [tmlf_pkg::SAMPLE_W-1:0] rd_value,
	input  wire logic                          result_stall,
	output logic                               result_valid,
	output logic [tmlf_pkg::SAMPLE_W-1:0]      filtered_raw,
	output logic [tmlf_pkg::LUX_W-1:0]         lux_report
);
	import tmlf_pkg::*;

	localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int unsigned WIN_DIV = WINDOW_DEPTH - 2;
	localparam logic [REC_W-1:0] REC_WIN = REC_W'((64'd1 << REC_SHIFT) / WIN_DIV);

	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [X_W-1:0]      x_q;
	logic [P_W-1:0]      p_q;
	logic [X_W-1:0]      q_q;
	logic [X_W-1:0]      m_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic                valid_q;
	logic [SAMPLE_W-1:0] filtered_q;
	logic [LUX_W-1:0]    lux_q;

	logic [X_W-1:0]      div_c;
	logic [REC_W-1:0]    rec_c;
	logic [X_W-1:0]      q_est;
	logic [X_W-1:0]      rem_c;
	logic                load;

	always_comb begin
		case (ctrl.sel)
			SEL_CAL1: begin
				div_c = X_W'(DIV_CAL1);
				rec_c = REC_CAL1;
			end
			SEL_CAL2: begin
				div_c = X_W'(DIV_CAL2);
				rec_c = REC_CAL2;
			end
			default: begin
				div_c = X_W'(WIN_DIV);
				rec_c = REC_WIN;
			end
		endcase
	end

	assign q_est = p_q[REC_SHIFT +: X_W];
	assign rem_c = x_q - m_q;
	assign load  = exec && (ctrl.op == OP_OUT);

	always_ff @(posedge clk) begin
		if (exec) begin
			case (ctrl.op)
				OP_CLEAR: begin
					sum_q <= '0;
					hi_q  <= '0;
					lo_q  <= '1;
				end
				OP_ACC: begin
					sum_q <= sum_q + SUM_W'(rd_value);
					if (rd_value > hi_q) begin
						hi_q <= rd_value;
					end
					if (rd_value < lo_q) begin
						lo_q <= rd_value;
					end
				end
				OP_TRIM:   x_q <= X_W'(sum_q - SUM_W'(hi_q) - SUM_W'(lo_q));
				OP_MULREC: p_q <= P_W'(x_q) * P_W'(rec_c);
				OP_MULDIV: begin
					q_q <= q_est;
					m_q <= q_est * div_c;
				end
				OP_CORR:   x_q <= (rem_c >= div_c) ? q_q + X_W'(1) : q_q;
				OP_SCALE: begin
					mean_q <= x_q[SAMPLE_W-1:0];
					x_q    <= x_q * X_W'(K_SCALE);
				end
				OP_GAIN:   x_q <= x_q * X_W'(K_GAIN);
				OP_OUT: begin
					filtered_q <= mean_q;
					lux_q      <= x_q[LUX_W-1:0] + LUX_W'(LUX_OFFSET);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign filtered_raw = filtered_q;
	assign lux_report   = lux_q;

endmodule

`default_nettype wire

>>> src/trimmed_mean_lux_filter_top.sv
// trimmed_mean_lux_filter_top: microcoded trimmed-mean light filter, top level
// depends on tmlf_pkg, tmlf_seq, tmlf_window, tmlf_dpath
//
// input channel: raw_sample and restart, with sample_valid and sample_stall
// output channel: filtered_raw and lux_report, with result_valid and result_stall
// an item is taken at a clock edge with valid high and stall low
// each input item gives exactly one result item
// a sample with restart set, or the first sample after reset, refills the window
// timing: a new item is taken only once the control program is back in its idle step,
// after walking the window once through a single read port
// then three reciprocal multiply, back-multiply and correct passes
// sample_stall is low only while the sequencer waits in its idle step
// a waiting result sits in the output register; the next item is still taken
// and the program holds at its last step until that result is taken
// reset clears the step counter, valid bits, write position and result_valid
`default_nettype none

module trimmed_mean_lux_filter_top #(
	parameter int unsigned WINDOW_DEPTH = tmlf_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic [tmlf_pkg::SAMPLE_W-1:0] raw_sample,
	input  wire logic                          restart,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [tmlf_pkg::SAMPLE_W-1:0]      filtered_raw,
	output logic [tmlf_pkg::LUX_W-1:0]         lux_report
);
	import tmlf_pkg::*;

	ctrl_t               ctrl;
	logic                exec;
	logic                in_fire;
	logic                out_busy;
	logic                more;
	logic [SAMPLE_W-1:0] rd_value;

	assign sample_stall = !ctrl.wait_in;
	assign in_fire      = sample_valid && !sample_stall;
	assign out_busy     = result_valid && result_stall;

	tmlf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_busy (out_busy),
		.more     (more),
		.ctrl     (ctrl),
		.exec     (exec)
	);

	tmlf_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_fire),
		.sample   (raw_sample),
		.restart  (restart),
		.ctrl     (ctrl),
		.exec     (exec),
		.more     (more),
		.rd_value (rd_value)
	);

	tmlf_dpath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.exec         (exec),
		.rd_value     (rd_value),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.filtered_raw (filtered_raw),
		.lux_report   (lux_report)
	);

endmodule

`default_nettype wire
